>>> hdl/stpr_pkg.sv
// ----------------------------------------------------------------------------
// Stepper ramp package
// Shared constants, widths and command codes of the trapezoidal stepper
// ramp generator.
// ----------------------------------------------------------------------------
`default_nettype none

package stpr_pkg;

    // Number of speed levels held in the period and step tables.
    localparam int unsigned TABLE_DEPTH = 20;
    localparam int unsigned LVL_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned LVL_MAX     = TABLE_DEPTH - 1;
    localparam int unsigned LVL_TOP_RST = (19 <= LVL_MAX) ? 19 : LVL_MAX;

    // Field widths.
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned INDEX_W  = 5;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned STEPS_W  = 15;
    localparam int unsigned POS_W    = 16;
    localparam int unsigned ACC_W    = 20;

    // Item commands.
    localparam logic [MODE_W-1:0] MODE_LOAD    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_START   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TICK    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_STOP    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DISABLE = 3'd4;

endpackage

`default_nettype wire

>>> hdl/stpr_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module stpr_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 20
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                           i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output      logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hdl/stepper_trapezoid_ramp_top.sv
// ----------------------------------------------------------------------------
// Trapezoidal stepper ramp generator
// Step pulse, direction and speed-ramp sequencer for one stepper axis.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the input channel (i_in_valid / o_in_stall) and each one
// produces exactly one result on the output channel (o_out_valid /
// i_out_stall). A transfer takes place at a rising edge with valid high and
// stall low. Load items fill the period and step tables, a start item plans a
// move, tick items come from the step timer, and stop and disable items end a
// move early or switch the driver off.
// One item is worked at a time by a small sequencer. From the accepting edge,
// load, stop, disable and unused codes, a start at the current position and a
// tick that takes no step go through S_PER and S_OUT; a stepping tick goes
// through S_RDA, S_RDB, S_APPLY, S_PER and S_OUT; any other start goes through
// S_SUM, which sweeps the step table one entry per cycle through its single
// read port, then S_SUMEND, S_PROF, S_PER and S_OUT. The result is registered
// when S_OUT finds the output register free, and the next item is accepted in
// the cycle after the result is registered.
// Reset clears the ramp state (idle, step line high, position zero, driver
// off); the tables are undefined until loaded. If the receiver stalls, the
// finished result waits in the output register and the next item may be
// accepted; its own result then waits in the sequencer until the register
// frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_trapezoid_ramp_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input channel
    input  wire logic        i_in_valid,
    output      logic        o_in_stall,
    input  wire logic [2:0]  i_mode,
    input  wire logic [4:0]  i_table_index,
    input  wire logic [15:0] i_table_period,
    input  wire logic [14:0] i_table_steps,
    input  wire logic signed [15:0] i_target_position,
    input  wire logic [4:0]  i_speed_index,
    // Output channel
    output      logic        o_out_valid,
    input  wire logic        i_out_stall,
    output      logic        o_step_level,
    output      logic        o_direction,
    output      logic        o_driver_enabled,
    output      logic [15:0] o_tick_period,
    output      logic        o_ticking,
    output      logic        o_busy_res,
    output      logic signed [15:0] o_position
);

    localparam int unsigned LW = stpr_pkg::LVL_W;

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RDA    = 4'd1;
    localparam logic [3:0] S_RDB    = 4'd2;
    localparam logic [3:0] S_APPLY  = 4'd3;
    localparam logic [3:0] S_SUM    = 4'd4;
    localparam logic [3:0] S_SUMEND = 4'd5;
    localparam logic [3:0] S_PROF   = 4'd6;
    localparam logic [3:0] S_PER    = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    // Ramp phases.
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_UP   = 3'd1;
    localparam logic [2:0] PH_MAX  = 3'd2;
    localparam logic [2:0] PH_DOWN = 3'd3;
    localparam logic [2:0] PH_LAST = 3'd4;

    localparam logic [LW-1:0] LVL_ZERO = '0;
    localparam logic [LW-1:0] LVL_ONE  = LW'(1);
    localparam logic [LW-1:0] LVL_TOP  = LW'(stpr_pkg::LVL_MAX);

    // Sequencer and ramp state.
    logic [3:0]    r_state,  n_state;
    logic [2:0]    r_phase,  n_phase;
    logic          r_pulse,  n_pulse;
    logic          r_half,   n_half;
    logic [15:0]   r_steps,  n_steps;
    logic [15:0]   r_mlen,   n_mlen;
    logic [15:0]   r_mid,    n_mid;
    logic [15:0]   r_decel,  n_decel;
    logic [19:0]   r_accel,  n_accel;
    logic [19:0]   r_nchg,   n_nchg;
    logic [LW-1:0] r_level,  n_level;
    logic [LW-1:0] r_top,    n_top;
    logic          r_sign,   n_sign;
    logic [15:0]   r_pos,    n_pos;
    logic          r_enable, n_enable;
    logic          r_tick_en, n_tick_en;
    logic [LW-1:0] r_cnt,    n_cnt;
    logic          r_acc_en, n_acc_en;
    logic [14:0]   r_da,     n_da;

    // Output register.
    logic          r_out_valid, n_out_valid;
    logic          r_out_step, r_out_dir, r_out_en, r_out_tick, r_out_busy;
    logic [15:0]   r_out_period;
    logic [15:0]   r_out_pos;
    logic          w_out_load;

    // Table memories.
    logic          w_load_we;
    logic [LW-1:0] w_load_addr;
    logic [LW-1:0] w_st_raddr;
    logic [14:0]   w_st_rdata;
    logic [15:0]   w_per_rdata;

    // Datapath helpers.
    logic          w_in_xfer;
    logic [LW-1:0] w_lvl_up, w_lvl_dn, w_addr_a, w_addr_b, w_top_sat;
    logic          w_trap;
    logic signed [16:0] w_diff;
    logic [16:0]   w_mark;

    assign w_in_xfer  = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    // A load item writes both tables at the accepting edge; out-of-range
    // indexes are dropped.
    assign w_load_we   = w_in_xfer && (i_mode == stpr_pkg::MODE_LOAD) &&
                         (32'(i_table_index) < stpr_pkg::TABLE_DEPTH);
    assign w_load_addr = LW'(i_table_index);

    // Speed level of a start saturates at the last table entry.
    assign w_top_sat = (32'(i_speed_index) > stpr_pkg::LVL_MAX) ? LVL_TOP
                                                                : LW'(i_speed_index);

    // Signed distance from the current position to the target.
    assign w_diff = 17'(i_target_position) - 17'($signed(r_pos));

    // Trapezoid when the move is longer than twice the ramp length.
    assign w_trap = {5'b0, r_mlen} > {r_accel, 1'b0};

    // Neighbor levels, clamped to the table so the read address stays legal.
    assign w_lvl_up = (r_level >= LVL_TOP) ? r_level : r_level + LVL_ONE;
    assign w_lvl_dn = (r_level == LVL_ZERO) ? LVL_ZERO : r_level - LVL_ONE;

    // A tick reads up to two step entries: A in S_RDA and B in S_RDB.
    always_comb begin
        if (r_phase == PH_DOWN) begin
            w_addr_a = (r_level == r_top) ? r_level : w_lvl_dn;
            w_addr_b = w_lvl_dn;
        end else if (r_level == LVL_ZERO) begin
            w_addr_a = LVL_ZERO;
            w_addr_b = LVL_ONE;
        end else begin
            w_addr_a = w_lvl_up;
            w_addr_b = w_lvl_up;
        end
    end

    always_comb begin
        case (r_state)
            S_RDA:   w_st_raddr = w_addr_a;
            S_RDB:   w_st_raddr = w_addr_b;
            default: w_st_raddr = r_cnt;
        endcase
    end

    // Deceleration mark at the top level; kept one bit wider than a position.
    assign w_mark = 17'(r_decel) + 17'(r_da);

    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_pulse   = r_pulse;
        n_half    = r_half;
        n_steps   = r_steps;
        n_mlen    = r_mlen;
        n_mid     = r_mid;
        n_decel   = r_decel;
        n_accel   = r_accel;
        n_nchg    = r_nchg;
        n_level   = r_level;
        n_top     = r_top;
        n_sign    = r_sign;
        n_pos     = r_pos;
        n_enable  = r_enable;
        n_tick_en = r_tick_en;
        n_cnt     = r_cnt;
        n_acc_en  = r_acc_en;
        n_da      = r_da;

        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = S_PER;
                    case (i_mode)
                        stpr_pkg::MODE_START: begin
                            n_top   = w_top_sat;
                            n_accel = '0;
                            if (w_diff != 17'sd0) begin
                                n_sign   = !w_diff[16];
                                n_mlen   = w_diff[16] ? 16'(-w_diff) : w_diff[15:0];
                                n_cnt    = LVL_ZERO;
                                n_acc_en = 1'b0;
                                n_state  = S_SUM;
                            end
                        end
                        stpr_pkg::MODE_TICK: begin
                            if (r_tick_en) begin
                                if (r_phase == PH_UP || r_phase == PH_MAX ||
                                    r_phase == PH_DOWN) begin
                                    n_state = S_RDA;
                                end else begin
                                    n_phase   = PH_IDLE;
                                    n_tick_en = 1'b0;
                                end
                            end
                        end
                        stpr_pkg::MODE_STOP: begin
                            if (r_phase != PH_IDLE) begin
                                n_steps = r_decel;
                                n_phase = PH_DOWN;
                            end
                        end
                        stpr_pkg::MODE_DISABLE: begin
                            n_enable  = 1'b0;
                            n_tick_en = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_RDA: begin
                n_state = S_RDB;
            end

            S_RDB: begin
                n_da    = w_st_rdata;
                n_state = S_APPLY;
            end

            S_APPLY: begin
                // Entry B is on the read port now, entry A sits in r_da.
                n_pulse = !r_pulse;
                n_half  = !r_half;
                if (r_phase == PH_DOWN) begin
                    if (r_level == LVL_ZERO) begin
                        // Bottom level holds.
                    end else if (r_level == r_top) begin
                        if (17'(r_steps) == w_mark) begin
                            n_nchg  = 20'(w_mark) + 20'(w_st_rdata);
                            n_level = r_level - LVL_ONE;
                        end
                    end else if (20'(r_steps) == r_nchg) begin
                        n_level = r_level - LVL_ONE;
                        n_nchg  = r_nchg + 20'(w_st_rdata);
                    end
                    if (r_steps == r_mlen) begin
                        n_phase = PH_LAST;
                    end
                end else begin
                    if (r_level == LVL_ZERO) begin
                        if ({1'b0, r_da} == r_steps) begin
                            n_nchg  = r_nchg + 20'(r_da) + 20'(w_st_rdata);
                            n_level = LVL_ONE;
                        end
                    end else if (r_level == r_top || r_level >= LVL_TOP) begin
                        // Cruise level or end of table reached.
                    end else if (20'(r_steps) == r_nchg) begin
                        n_level = r_level + LVL_ONE;
                        n_nchg  = r_nchg + 20'(r_da);
                    end
                    if (r_phase == PH_UP) begin
                        if (r_steps == r_mid) begin
                            n_phase = w_trap ? PH_MAX : PH_DOWN;
                        end
                    end else if (r_steps == r_decel) begin
                        n_phase = PH_DOWN;
                    end
                end
                // The position moves on the second half of each step period.
                if (!r_half) begin
                    n_pos   = r_sign ? r_pos + 16'd1 : r_pos - 16'd1;
                    n_steps = r_steps + 16'd1;
                end
                n_state = S_PER;
            end

            S_SUM: begin
                // One step entry is read per cycle; the read data is registered behind its address.
                if (r_acc_en) begin
                    n_accel = r_accel + 20'(w_st_rdata);
                end
                n_acc_en = 1'b1;
                if (r_cnt == r_top) begin
                    n_state = S_SUMEND;
                end else begin
                    n_cnt = r_cnt + LVL_ONE;
                end
            end

            S_SUMEND: begin
                n_accel = r_accel + 20'(w_st_rdata);
                n_state = S_PROF;
            end

            S_PROF: begin
                if (w_trap) begin
                    n_mid   = r_accel[15:0];
                    n_decel = r_mlen - r_accel[15:0];
                end else begin
                    n_mid   = (r_mlen - 16'd1) >> 1;
                    n_decel = (r_mlen - 16'd1) >> 1;
                end
                n_steps   = '0;
                n_nchg    = '0;
                n_level   = LVL_ZERO;
                n_phase   = PH_UP;
                n_enable  = 1'b1;
                n_tick_en = 1'b1;
                n_state   = S_PER;
            end

            S_PER: begin
                // Period RAM is addressed by the settled level in this cycle.
                n_state = S_OUT;
            end

            S_OUT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_IDLE;
            r_pulse     <= 1'b1;
            r_half      <= 1'b0;
            r_steps     <= '0;
            r_mlen      <= '0;
            r_mid       <= '0;
            r_decel     <= '0;
            r_accel     <= '0;
            r_nchg      <= '0;
            r_level     <= LVL_ZERO;
            r_top       <= LW'(stpr_pkg::LVL_TOP_RST);
            r_sign      <= 1'b0;
            r_pos       <= '0;
            r_enable    <= 1'b0;
            r_tick_en   <= 1'b0;
            r_cnt       <= LVL_ZERO;
            r_acc_en    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_pulse     <= n_pulse;
            r_half      <= n_half;
            r_steps     <= n_steps;
            r_mlen      <= n_mlen;
            r_mid       <= n_mid;
            r_decel     <= n_decel;
            r_accel     <= n_accel;
            r_nchg      <= n_nchg;
            r_level     <= n_level;
            r_top       <= n_top;
            r_sign      <= n_sign;
            r_pos       <= n_pos;
            r_enable    <= n_enable;
            r_tick_en   <= n_tick_en;
            r_cnt       <= n_cnt;
            r_acc_en    <= n_acc_en;
            r_out_valid <= n_out_valid;
        end
    end

    // Scratch and result payload registers.
    always_ff @(posedge i_clk) begin
        r_da <= n_da;
        if (w_out_load) begin
            r_out_step   <= r_pulse;
            r_out_dir    <= r_sign;
            r_out_en     <= r_enable;
            r_out_period <= w_per_rdata;
            r_out_tick   <= r_tick_en;
            r_out_busy   <= (r_phase != PH_IDLE);
            r_out_pos    <= r_pos;
        end
    end

    stpr_ram #(
        .WIDTH (stpr_pkg::PERIOD_W),
        .DEPTH (stpr_pkg::TABLE_DEPTH)
    ) u_period_ram (
        .i_clk   (i_clk),
        .i_we    (w_load_we),
        .i_waddr (w_load_addr),
        .i_wdata (i_table_period),
        .i_raddr (r_level),
        .o_rdata (w_per_rdata)
    );

    stpr_ram #(
        .WIDTH (stpr_pkg::STEPS_W),
        .DEPTH (stpr_pkg::TABLE_DEPTH)
    ) u_step_ram (
        .i_clk   (i_clk),
        .i_we    (w_load_we),
        .i_waddr (w_load_addr),
        .i_wdata (i_table_steps),
        .i_raddr (w_st_raddr),
        .o_rdata (w_st_rdata)
    );

    assign o_out_valid      = r_out_valid;
    assign o_step_level     = r_out_step;
    assign o_direction      = r_out_dir;
    assign o_driver_enabled = r_out_en;
    assign o_tick_period    = r_out_period;
    assign o_ticking        = r_out_tick;
    assign o_busy_res       = r_out_busy;
    assign o_position       = $signed(r_out_pos);

endmodule

`default_nettype wire

>>> hdl/stpr_checker.sv
// ----------------------------------------------------------------------------
// Stepper ramp port checker
// Watches the ports of the ramp generator and flags illegal sequences.
// ----------------------------------------------------------------------------
`default_nettype none

module stpr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic [2:0]  i_mode,
    input wire logic [4:0]  i_table_index,
    input wire logic [15:0] i_table_period,
    input wire logic [14:0] i_table_steps,
    input wire logic [15:0] i_target_position,
    input wire logic [4:0]  i_speed_index,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic        o_step_level,
    input wire logic        o_direction,
    input wire logic        o_driver_enabled,
    input wire logic [15:0] o_tick_period,
    input wire logic        o_ticking,
    input wire logic        o_busy_res,
    input wire logic [15:0] o_position
);

    // A result held back by the receiver stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_position) && $stable(o_tick_period) &&
            $stable(o_step_level) && $stable(o_busy_res))
        else $error("stalled result changed");

    // Reset leaves no result on the output.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // An accepted item makes the sequencer busy, so items are never accepted back to back.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("item accepted back to back");

    // Timer requests only go out while the driver is on.
    a_tick_needs_driver: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_ticking |-> o_driver_enabled)
        else $error("ticking with driver disabled");

endmodule

bind stepper_trapezoid_ramp_top stpr_checker u_stpr_checker (.*);

`default_nettype wire
